/* rtl/rti_pkg.sv */
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types and constants of the ray/triangle intersection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rti_pkg;

  // Width of the hit distance result
  localparam int unsigned T_BITS = 24;

  // Item operation codes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_RAY  = 1'b1
  } op_e;

  // Vertex select codes of a load item
  localparam logic [1:0] VTX_A    = 2'd0;
  localparam logic [1:0] VTX_B    = 2'd1;
  localparam logic [1:0] VTX_C    = 2'd2;
  localparam logic [1:0] VTX_NONE = 2'd3;  // no vertex, load is ignored

endpackage

`default_nettype wire

/* rtl/rti_in_if.sv */
// ----------------------------------------------------------------------------
// rti_in_if
// Input channel: vertex loads and ray tests, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rti_in_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [1:0]                   vertex_index;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] vertex_z;
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic signed [COORD_BITS-1:0] origin_z;
  logic signed [COORD_BITS-1:0] dir_x;
  logic signed [COORD_BITS-1:0] dir_y;
  logic signed [COORD_BITS-1:0] dir_z;

  modport source (
    output valid, op, vertex_index, vertex_x, vertex_y, vertex_z,
           origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    input  ready
  );
  modport sink (
    input  valid, op, vertex_index, vertex_x, vertex_y, vertex_z,
           origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/rti_out_if.sv */
// ----------------------------------------------------------------------------
// rti_out_if
// Result channel: hit flag and distance, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rti_out_if
  import rti_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [T_BITS-1:0] t_value;

  modport source (output valid, hit, t_value, input ready);
  modport sink   (input valid, hit, t_value, output ready);
endinterface

`default_nettype wire

/* rtl/ray_triangle_intersection.sv */
// ----------------------------------------------------------------------------
// ray_triangle_intersection
// Pipelined Moller-Trumbore ray/triangle test in exact fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   ray_i carries items. A load item (op 0) writes one vertex of the stored
//   triangle at the accepting edge and gives no result; vertex index three
//   is ignored. A ray item (op 1) takes a snapshot of the triangle as left
//   by all earlier loads and gives exactly one result on res_o.
//   Throughput: one item per cycle while the output is not stalled. A ray
//   result passes the capture register, seven arithmetic stages, one
//   restoring divider step per bit of the distance and the output register.
//   Stalls: every stage has a valid bit and holds while the stage after it
//   is full and stalled, so bubbles are squeezed out and input is taken as
//   long as any stage ahead can move; nothing is lost or repeated.
//   Reset clears all valid bits and sets the stored triangle to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_intersection
  import rti_pkg::*;
#(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  rti_in_if.sink     ray_i,
  rti_out_if.source  res_o
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned DW   = CB + 1;          // edge / offset width
  localparam int unsigned PW   = 2 * DW;          // cross product width
  localparam int unsigned LW   = 2 * DW + 1;      // low partial product
  localparam int unsigned HW   = 2 * DW;          // high partial product
  localparam int unsigned FW   = 3 * DW;          // full product
  localparam int unsigned DOTW = 3 * DW + 2;      // dot product
  localparam int unsigned RW   = DOTW + T_BITS + FRAC_BITS;
  localparam int unsigned NST  = 9 + T_BITS;      // stages incl. output
  localparam int unsigned SDIV = 8;               // first divider stage

  typedef logic signed [DW-1:0]   dv_t;
  typedef logic signed [PW-1:0]   pv_t;
  typedef logic signed [DOTW-1:0] dot_t;

  // Stage valid bits and per-stage advance
  logic [NST-1:0] vld_q;
  logic [NST-1:0] en_c;

  always_comb begin
    en_c[NST-1] = !vld_q[NST-1] || res_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en_c[k] = !vld_q[k] || en_c[k+1];
    end
  end

  assign ray_i.ready = en_c[0];

  logic acc_c;
  assign acc_c = ray_i.valid && en_c[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en_c[0]) begin
        vld_q[0] <= ray_i.valid && (op_e'(ray_i.op) == OP_RAY);
      end
      for (int k = 1; k < NST; k++) begin
        if (en_c[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stored triangle: A, B, C each x, y, z
  logic signed [CB-1:0] vtx_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        vtx_q[i] <= '0;
      end
    end else if (acc_c && (op_e'(ray_i.op) == OP_LOAD)) begin
      case (ray_i.vertex_index)
        VTX_A: begin
          vtx_q[0] <= ray_i.vertex_x;
          vtx_q[1] <= ray_i.vertex_y;
          vtx_q[2] <= ray_i.vertex_z;
        end
        VTX_B: begin
          vtx_q[3] <= ray_i.vertex_x;
          vtx_q[4] <= ray_i.vertex_y;
          vtx_q[5] <= ray_i.vertex_z;
        end
        VTX_C: begin
          vtx_q[6] <= ray_i.vertex_x;
          vtx_q[7] <= ray_i.vertex_y;
          vtx_q[8] <= ray_i.vertex_z;
        end
        default: begin
        end
      endcase
    end
  end

  // Stage 0: capture ray and triangle snapshot
  logic signed [CB-1:0] s0_vtx_q [9];
  logic signed [CB-1:0] s0_o_q [3];
  logic signed [CB-1:0] s0_d_q [3];

  always_ff @(posedge clk_i) begin
    if (en_c[0]) begin
      for (int i = 0; i < 9; i++) begin
        s0_vtx_q[i] <= vtx_q[i];
      end
      s0_o_q[0] <= ray_i.origin_x;
      s0_o_q[1] <= ray_i.origin_y;
      s0_o_q[2] <= ray_i.origin_z;
      s0_d_q[0] <= ray_i.dir_x;
      s0_d_q[1] <= ray_i.dir_y;
      s0_d_q[2] <= ray_i.dir_z;
    end
  end

  // Stage 1: edges e1, e2 and offset s
  dv_t                  s1_e1_q [3];
  dv_t                  s1_e2_q [3];
  dv_t                  s1_s_q  [3];
  logic signed [CB-1:0] s1_d_q  [3];

  always_ff @(posedge clk_i) begin
    if (en_c[1]) begin
      for (int i = 0; i < 3; i++) begin
        s1_e1_q[i] <= DW'(s0_vtx_q[3+i]) - DW'(s0_vtx_q[i]);
        s1_e2_q[i] <= DW'(s0_vtx_q[6+i]) - DW'(s0_vtx_q[i]);
        s1_s_q[i]  <= DW'(s0_o_q[i]) - DW'(s0_vtx_q[i]);
        s1_d_q[i]  <= s0_d_q[i];
      end
    end
  end

  // Stage 2: p = d x e2, q = s x e1
  pv_t  s2_p_q  [3];
  pv_t  s2_q_q  [3];
  dv_t  s2_e1_q [3];
  dv_t  s2_e2_q [3];
  dv_t  s2_s_q  [3];
  dv_t  s2_d_q  [3];

  always_ff @(posedge clk_i) begin
    if (en_c[2]) begin
      for (int i = 0; i < 3; i++) begin
        s2_p_q[i] <= PW'(s1_d_q[(i+1)%3]) * PW'(s1_e2_q[(i+2)%3])
                   - PW'(s1_d_q[(i+2)%3]) * PW'(s1_e2_q[(i+1)%3]);
        s2_q_q[i] <= PW'(s1_s_q[(i+1)%3]) * PW'(s1_e1_q[(i+2)%3])
                   - PW'(s1_s_q[(i+2)%3]) * PW'(s1_e1_q[(i+1)%3]);
        s2_e1_q[i] <= s1_e1_q[i];
        s2_e2_q[i] <= s1_e2_q[i];
        s2_s_q[i]  <= s1_s_q[i];
        s2_d_q[i]  <= DW'(s1_d_q[i]);
      end
    end
  end

  // Stage 3: split partial products of the four dot products
  // dot index: 0 det = e1.p, 1 un = s.p, 2 vn = d.q, 3 tn = e2.q
  logic signed [HW-1:0] s3_ph_q [4][3];
  logic signed [LW-1:0] s3_pl_q [4][3];

  always_ff @(posedge clk_i) begin
    if (en_c[3]) begin
      for (int i = 0; i < 3; i++) begin
        s3_ph_q[0][i] <= HW'(s2_e1_q[i]) * HW'($signed(s2_p_q[i][PW-1:DW]));
        s3_pl_q[0][i] <= LW'(s2_e1_q[i]) * LW'($signed({1'b0, s2_p_q[i][DW-1:0]}));
        s3_ph_q[1][i] <= HW'(s2_s_q[i]) * HW'($signed(s2_p_q[i][PW-1:DW]));
        s3_pl_q[1][i] <= LW'(s2_s_q[i]) * LW'($signed({1'b0, s2_p_q[i][DW-1:0]}));
        s3_ph_q[2][i] <= HW'(s2_d_q[i]) * HW'($signed(s2_q_q[i][PW-1:DW]));
        s3_pl_q[2][i] <= LW'(s2_d_q[i]) * LW'($signed({1'b0, s2_q_q[i][DW-1:0]}));
        s3_ph_q[3][i] <= HW'(s2_e2_q[i]) * HW'($signed(s2_q_q[i][PW-1:DW]));
        s3_pl_q[3][i] <= LW'(s2_e2_q[i]) * LW'($signed({1'b0, s2_q_q[i][DW-1:0]}));
      end
    end
  end

  // Stage 4: recombine partials and sum the three terms
  dot_t s4_dot_q [4];

  always_ff @(posedge clk_i) begin
    if (en_c[4]) begin
      for (int k = 0; k < 4; k++) begin
        s4_dot_q[k] <=
            DOTW'((FW'(s3_ph_q[k][0]) <<< DW) + FW'(s3_pl_q[k][0]))
          + DOTW'((FW'(s3_ph_q[k][1]) <<< DW) + FW'(s3_pl_q[k][1]))
          + DOTW'((FW'(s3_ph_q[k][2]) <<< DW) + FW'(s3_pl_q[k][2]));
      end
    end
  end

  // Stage 5: make the determinant non-negative, negating all four dot products together
  dot_t s5_dot_q [4];

  always_ff @(posedge clk_i) begin
    if (en_c[5]) begin
      for (int k = 0; k < 4; k++) begin
        s5_dot_q[k] <= s4_dot_q[0][DOTW-1] ? -s4_dot_q[k] : s4_dot_q[k];
      end
    end
  end

  // Stage 6: inside tests, numerator and divisor
  logic                s6_hit_q;
  logic [RW-1:0]       s6_num_q;
  logic [RW-1:0]       s6_den_q;
  logic signed [DOTW:0] uv_c;

  assign uv_c = (DOTW+1)'(s5_dot_q[1]) + (DOTW+1)'(s5_dot_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_c[6]) begin
      s6_hit_q <= (s5_dot_q[0] != '0)
               && !s5_dot_q[1][DOTW-1] && (s5_dot_q[1] <= s5_dot_q[0])
               && !s5_dot_q[2][DOTW-1] && (uv_c <= (DOTW+1)'(s5_dot_q[0]))
               && !s5_dot_q[3][DOTW-1] && (s5_dot_q[3] != '0);
      s6_num_q <= RW'($unsigned(s5_dot_q[3])) << FRAC_BITS;
      s6_den_q <= RW'($unsigned(s5_dot_q[0]));
    end
  end

  // Stage 7 and divider: restoring division, one quotient bit per stage
  logic [RW-1:0]     dv_r_q   [T_BITS+1];
  logic [RW-1:0]     dv_d_q   [T_BITS+1];
  logic [T_BITS-1:0] dv_t_q   [T_BITS+1];
  logic              dv_hit_q [T_BITS+1];
  logic              dv_sat_q [T_BITS+1];

  always_ff @(posedge clk_i) begin
    if (en_c[SDIV-1]) begin
      dv_r_q[0]   <= s6_num_q;
      dv_d_q[0]   <= s6_den_q;
      dv_t_q[0]   <= '0;
      dv_hit_q[0] <= s6_hit_q;
      dv_sat_q[0] <= s6_num_q >= (s6_den_q << T_BITS);
    end
  end

  for (genvar j = 0; j < T_BITS; j++) begin : g_div
    localparam int unsigned BI = T_BITS - 1 - j;
    logic [RW-1:0] sh_c;
    assign sh_c = dv_d_q[j] << BI;

    always_ff @(posedge clk_i) begin
      if (en_c[SDIV+j]) begin
        dv_d_q[j+1]   <= dv_d_q[j];
        dv_hit_q[j+1] <= dv_hit_q[j];
        dv_sat_q[j+1] <= dv_sat_q[j];
        if (dv_r_q[j] >= sh_c) begin
          dv_r_q[j+1]     <= dv_r_q[j] - sh_c;
          dv_t_q[j+1]     <= dv_t_q[j] | (T_BITS'(1) << BI);
        end else begin
          dv_r_q[j+1]     <= dv_r_q[j];
          dv_t_q[j+1]     <= dv_t_q[j];
        end
      end
    end
  end

  // Output register
  logic              out_hit_q;
  logic [T_BITS-1:0] out_t_q;

  always_ff @(posedge clk_i) begin
    if (en_c[NST-1]) begin
      out_hit_q <= dv_hit_q[T_BITS];
      if (!dv_hit_q[T_BITS]) begin
        out_t_q <= '0;
      end else if (dv_sat_q[T_BITS]) begin
        out_t_q <= '1;
      end else begin
        out_t_q <= dv_t_q[T_BITS];
      end
    end
  end

  assign res_o.valid   = vld_q[NST-1];
  assign res_o.hit     = out_hit_q;
  assign res_o.t_value = out_t_q;

endmodule

`default_nettype wire
